>>> rtl/box_intersection_over_union_defines.svh
// ----------------------------------------------------------------------------
// Box IoU assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BOX_INTERSECTION_OVER_UNION_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_DEFINES_SVH

`ifndef SYNTH
`define BIOU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BIOU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BIOU_ASSERT(lbl, prop, msg)
`define BIOU_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/biou_pkg.sv
// ----------------------------------------------------------------------------
// Box IoU package
// Widths and shared types of the box intersection over union pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package biou_pkg;

    localparam int COORD_W    = 16;
    localparam int SIZE_W     = 15;
    localparam int EDGE_W     = COORD_W + 1;
    localparam int AREA_W     = 2 * SIZE_W;
    localparam int UNION_W    = AREA_W + 1;
    localparam int FRAC_BITS  = 16;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int CELLS      = QUO_W;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic valid;
        logic uz;
    } t_ctl;

endpackage

`default_nettype wire

>>> rtl/biou_area.sv
// ----------------------------------------------------------------------------
// Box IoU area front end
// Three stages: overlap extents, area products, union and divider seed.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_area (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [biou_pkg::COORD_W-1:0]  i_a_x,
    input  wire logic signed [biou_pkg::COORD_W-1:0]  i_a_y,
    input  wire logic        [biou_pkg::SIZE_W-1:0]   i_a_width,
    input  wire logic        [biou_pkg::SIZE_W-1:0]   i_a_height,
    input  wire logic signed [biou_pkg::COORD_W-1:0]  i_b_x,
    input  wire logic signed [biou_pkg::COORD_W-1:0]  i_b_y,
    input  wire logic        [biou_pkg::SIZE_W-1:0]   i_b_width,
    input  wire logic        [biou_pkg::SIZE_W-1:0]   i_b_height,
    input  wire logic                                 i_ready,
    output biou_pkg::t_ctl                            o_ctl,
    output logic             [biou_pkg::UNION_W-1:0]  o_rem,
    output logic             [biou_pkg::UNION_W-1:0]  o_div,
    output logic                                      o_bit
);

    localparam int EW = biou_pkg::EDGE_W;
    localparam int SW = biou_pkg::SIZE_W;
    localparam int AW = biou_pkg::AREA_W;
    localparam int UW = biou_pkg::UNION_W;

    logic w_load0, w_load1, w_load2;
    logic r_v0, r_v1, r_v2;

    // stage 0: overlap extents
    logic signed [EW-1:0] w_ax, w_ay, w_bx, w_by, w_ar, w_ab, w_br, w_bb;
    logic signed [EW-1:0] w_ow, w_oh;
    logic                 w_sep;
    logic [SW-1:0] r_ow, r_oh, r_aw, r_ah, r_bw, r_bh;
    logic [SW-1:0] n_ow, n_oh;

    // stage 1: products
    logic [AW-1:0] r_inter, r_area_a, r_area_b;

    // stage 2: union
    logic [UW-1:0] r_uni, r_rem, n_uni;
    logic          r_uz, r_bit;

    assign w_load2 = !r_v2 || i_ready;
    assign w_load1 = !r_v1 || w_load2;
    assign w_load0 = !r_v0 || w_load1;
    assign o_ready = w_load0;

    always_comb begin
        w_ax = EW'(i_a_x);
        w_ay = EW'(i_a_y);
        w_bx = EW'(i_b_x);
        w_by = EW'(i_b_y);
        w_ar = w_ax + $signed({2'b00, i_a_width});
        w_ab = w_ay + $signed({2'b00, i_a_height});
        w_br = w_bx + $signed({2'b00, i_b_width});
        w_bb = w_by + $signed({2'b00, i_b_height});
        w_sep = (w_br < w_ax) || (w_ar < w_bx) || (w_bb < w_ay) || (w_ab < w_by);
        w_ow = ((w_ar < w_br) ? w_ar : w_br) - ((w_ax > w_bx) ? w_ax : w_bx);
        w_oh = ((w_ab < w_bb) ? w_ab : w_bb) - ((w_ay > w_by) ? w_ay : w_by);
        n_ow = w_sep ? '0 : w_ow[SW-1:0];
        n_oh = w_sep ? '0 : w_oh[SW-1:0];
        n_uni = {1'b0, r_area_a} + {1'b0, r_area_b} - {1'b0, r_inter};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_load0) r_v0 <= i_valid;
            if (w_load1) r_v1 <= r_v0;
            if (w_load2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load0) begin
            r_ow <= n_ow;
            r_oh <= n_oh;
            r_aw <= i_a_width;
            r_ah <= i_a_height;
            r_bw <= i_b_width;
            r_bh <= i_b_height;
        end
        if (w_load1) begin
            r_inter  <= r_ow * r_oh;
            r_area_a <= r_aw * r_ah;
            r_area_b <= r_bw * r_bh;
        end
        if (w_load2) begin
            r_uni <= n_uni;
            r_uz  <= (n_uni == '0);
            r_rem <= UW'(r_inter[AW-1:1]);
            r_bit <= r_inter[0];
        end
    end

    assign o_ctl = '{valid: r_v2, uz: r_uz};
    assign o_rem = r_rem;
    assign o_div = r_uni;
    assign o_bit = r_bit;

endmodule

`default_nettype wire

>>> rtl/biou_div_cell.sv
// ----------------------------------------------------------------------------
// Box IoU divider cell
// One restoring division step: shift in a bit, trial subtract, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module biou_div_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire biou_pkg::t_ctl                      i_ctl,
    output logic                                     o_ready,
    input  wire logic [biou_pkg::UNION_W-1:0]        i_rem,
    input  wire logic [biou_pkg::UNION_W-1:0]        i_div,
    input  wire logic [biou_pkg::QUO_W-1:0]          i_quo,
    input  wire logic                                i_bit,
    input  wire logic                                i_ready,
    output biou_pkg::t_ctl                           o_ctl,
    output logic      [biou_pkg::UNION_W-1:0]        o_rem,
    output logic      [biou_pkg::UNION_W-1:0]        o_div,
    output logic      [biou_pkg::QUO_W-1:0]          o_quo
);

    localparam int UW = biou_pkg::UNION_W;
    localparam int QW = biou_pkg::QUO_W;

    logic          w_load;
    logic [UW:0]   w_trial;
    logic [UW+1:0] w_diff;
    logic          w_ge;
    logic [UW-1:0] n_rem;
    logic [QW-1:0] n_quo;

    logic          r_valid, r_uz;
    logic [UW-1:0] r_rem, r_div;
    logic [QW-1:0] r_quo;

    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    always_comb begin
        w_trial = {i_rem, i_bit};
        w_diff  = {1'b0, w_trial} - {2'b00, i_div};
        w_ge    = !w_diff[UW+1];
        n_rem   = w_ge ? w_diff[UW-1:0] : w_trial[UW-1:0];
        n_quo   = {i_quo[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_uz  <= i_ctl.uz;
            r_rem <= n_rem;
            r_div <= i_div;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = '{valid: r_valid, uz: r_uz};
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

`default_nettype wire

>>> rtl/box_intersection_over_union.sv
// ----------------------------------------------------------------------------
// Box intersection over union
// Streams box pairs in, IoU ratios out as unsigned Q1.16.
// ----------------------------------------------------------------------------
// Slave channel: one word per box pair, accepted on i_s_tvalid && o_s_tready.
// Master channel: one word per pair: tdata holds the ratio (65536 = 1.0,
// truncated), tuser flags a zero union, in which case the ratio is 0.
// From acceptance to o_m_tvalid a word passes three front stages
// (overlap, area products, union) and a chain of 17 divider cells, one
// quotient bit per cell. Throughput is one word per cycle while the
// receiver does not stall.
// Every stage holds its own valid bit and loads when it is empty or its
// successor loads, so a stalled receiver only fills the pipeline: new words
// are taken until each stage holds one, and bubbles close up on their own.
// Reset (synchronous, active low) empties the pipeline; no word is in flight
// after it and o_m_tvalid is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_intersection_over_union_defines.svh"

module box_intersection_over_union (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_tvalid,
    output logic                                       o_s_tready,
    // a_x[15:0] a_y[31:16] a_width[46:32] a_height[61:47]
    // b_x[77:62] b_y[93:78] b_width[108:94] b_height[123:109], zero fill
    input  wire logic [biou_pkg::IN_DATA_W-1:0]        i_s_tdata,
    output logic                                       o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // ratio[16:0], zero fill
    output logic      [biou_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    // union_zero[0]
    output logic      [0:0]                            o_m_tuser
);

    localparam int UW = biou_pkg::UNION_W;
    localparam int QW = biou_pkg::QUO_W;
    localparam int NC = biou_pkg::CELLS;

    biou_pkg::t_ctl w_ctl   [0:NC];
    logic [UW-1:0]  w_rem   [0:NC];
    logic [UW-1:0]  w_div   [0:NC];
    logic [QW-1:0]  w_quo   [0:NC];
    logic           w_ready [0:NC];
    logic           w_bit;
    logic [QW-1:0]  w_ratio;

    biou_area u_area (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_a_x      (i_s_tdata[15:0]),
        .i_a_y      (i_s_tdata[31:16]),
        .i_a_width  (i_s_tdata[46:32]),
        .i_a_height (i_s_tdata[61:47]),
        .i_b_x      (i_s_tdata[77:62]),
        .i_b_y      (i_s_tdata[93:78]),
        .i_b_width  (i_s_tdata[108:94]),
        .i_b_height (i_s_tdata[123:109]),
        .i_ready    (w_ready[0]),
        .o_ctl      (w_ctl[0]),
        .o_rem      (w_rem[0]),
        .o_div      (w_div[0]),
        .o_bit      (w_bit)
    );

    assign w_quo[0] = '0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic w_cell_bit;
        if (k == 0) begin : g_first
            assign w_cell_bit = w_bit;
        end else begin : g_rest
            assign w_cell_bit = 1'b0;
        end

        biou_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .o_ready (w_ready[k]),
            .i_rem   (w_rem[k]),
            .i_div   (w_div[k]),
            .i_quo   (w_quo[k]),
            .i_bit   (w_cell_bit),
            .i_ready (w_ready[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_div   (w_div[k+1]),
            .o_quo   (w_quo[k+1])
        );
    end

    assign w_ready[NC] = i_m_tready;
    assign w_ratio     = w_ctl[NC].uz ? '0 : w_quo[NC];

    assign o_m_tvalid   = w_ctl[NC].valid;
    assign o_m_tdata    = biou_pkg::OUT_DATA_W'(w_ratio);
    assign o_m_tuser[0] = w_ctl[NC].uz;

    `BIOU_ASSERT(a_uz_ratio, o_m_tvalid && o_m_tuser[0] |-> (w_ratio == '0), "zero union with ratio")
    `BIOU_ASSERT(a_ratio_max, o_m_tvalid |-> !(w_ratio[QW-1] && (w_ratio[QW-2:0] != '0)), "ratio above one")
    `BIOU_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_m_tvalid, "word out after reset")

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box intersection over union testbench
// Streams box pairs into the pipeline: first hand-picked extremes, touching,
// separated, flat and nested boxes, then shaped random pairs with random gaps
// on both channels. Each output word is checked field by field against an
// in-order queue of ratios computed by an independent integer model.
// ----------------------------------------------------------------------------
module tb;

    localparam int PIPE_LATENCY   = 20;
    localparam int DRAIN_CYCLES   = 2 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    // Packed from the top down so that a_x lands in bit 0 of tdata.
    typedef struct packed {
        logic        [14:0] b_h;
        logic        [14:0] b_w;
        logic signed [15:0] b_y;
        logic signed [15:0] b_x;
        logic        [14:0] a_h;
        logic        [14:0] a_w;
        logic signed [15:0] a_y;
        logic signed [15:0] a_x;
    } t_box_pair;

    typedef struct {
        logic [biou_pkg::QUO_W-1:0] ratio;
        logic                       union_zero;
    } t_iou_result;

    typedef enum int {
        SHAPE_RANDOM,
        SHAPE_OVERLAP,
        SHAPE_TOUCH,
        SHAPE_FLAT,
        SHAPE_NESTED
    } t_pair_shape;

    logic                              i_clk      = 1'b0;
    logic                              i_rst_n    = 1'b0;
    logic                              i_s_tvalid = 1'b0;
    logic                              o_s_tready;
    logic [biou_pkg::IN_DATA_W-1:0]    i_s_tdata  = '0;
    logic                              o_m_tvalid;
    logic                              i_m_tready = 1'b0;
    logic [biou_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic [0:0]                        o_m_tuser;

    t_iou_result iou_expected[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          rx_hold        = 0;
    bit          idle_on        = 1'b0;

    box_intersection_over_union dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_iou_result iou_predict(input t_box_pair p);
        longint      ax, ay, aw, ah, bx, by, bw, bh;
        longint      a_right, a_bottom, b_right, b_bottom;
        longint      ow, oh, overlap, union_area;
        t_iou_result r;
        ax = $signed(p.a_x);
        ay = $signed(p.a_y);
        aw = p.a_w;
        ah = p.a_h;
        bx = $signed(p.b_x);
        by = $signed(p.b_y);
        bw = p.b_w;
        bh = p.b_h;
        a_right  = ax + aw;
        a_bottom = ay + ah;
        b_right  = bx + bw;
        b_bottom = by + bh;
        overlap = 0;
        if (!(b_right < ax || a_right < bx || b_bottom < ay || a_bottom < by)) begin
            ow = ((a_right < b_right) ? a_right : b_right) - ((ax > bx) ? ax : bx);
            oh = ((a_bottom < b_bottom) ? a_bottom : b_bottom) - ((ay > by) ? ay : by);
            overlap = ow * oh;
        end
        union_area = aw * ah + bw * bh - overlap;
        if (union_area <= 0) begin
            r.ratio      = '0;
            r.union_zero = 1'b1;
        end else begin
            r.ratio      = biou_pkg::QUO_W'((overlap <<< biou_pkg::FRAC_BITS) / union_area);
            r.union_zero = 1'b0;
        end
        return r;
    endfunction

    function automatic t_box_pair make_pair(input int ax, ay, aw, ah, bx, by, bw, bh);
        t_box_pair p;
        p.a_x = 16'(ax);
        p.a_y = 16'(ay);
        p.a_w = 15'(aw);
        p.a_h = 15'(ah);
        p.b_x = 16'(bx);
        p.b_y = 16'(by);
        p.b_w = 15'(bw);
        p.b_h = 15'(bh);
        return p;
    endfunction

    // Mostly small boxes so overlaps are common; full range now and then.
    function automatic logic [14:0] rand_size();
        case ($urandom_range(0, 7))
            0:       return 15'($urandom);
            1:       return $urandom_range(0, 1) ? 15'h7fff : 15'h0000;
            default: return 15'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic t_box_pair random_pair();
        t_box_pair   p;
        t_pair_shape shape;
        int          pick;
        pick  = $urandom_range(0, 9);
        shape = (pick < 2) ? SHAPE_RANDOM :
                (pick < 7) ? SHAPE_OVERLAP :
                (pick < 8) ? SHAPE_TOUCH :
                (pick < 9) ? SHAPE_FLAT : SHAPE_NESTED;
        p.a_x = 16'($urandom);
        p.a_y = 16'($urandom);
        p.a_w = rand_size();
        p.a_h = rand_size();
        p.b_w = rand_size();
        p.b_h = rand_size();
        p.b_x = 16'($urandom);
        p.b_y = 16'($urandom);
        case (shape)
            SHAPE_RANDOM: begin
                p.a_w = 15'($urandom);
                p.a_h = 15'($urandom);
                p.b_w = 15'($urandom);
                p.b_h = 15'($urandom);
            end
            SHAPE_OVERLAP: begin
                p.b_x = 16'(int'(p.a_x) + int'($urandom_range(0, p.a_w + p.b_w)) - int'(p.b_w));
                p.b_y = 16'(int'(p.a_y) + int'($urandom_range(0, p.a_h + p.b_h)) - int'(p.b_h));
            end
            SHAPE_TOUCH: begin
                p.b_y = 16'(int'(p.a_y) + int'($urandom_range(0, p.a_h)));
                if ($urandom_range(0, 1))
                    p.b_x = 16'(int'(p.a_x) + int'(p.a_w));
                else
                    p.b_x = 16'(int'(p.a_x) - int'(p.b_w));
            end
            SHAPE_FLAT: begin
                p.b_x = 16'(int'(p.a_x) + int'($urandom_range(0, 20)) - 10);
                p.b_y = 16'(int'(p.a_y) + int'($urandom_range(0, 20)) - 10);
                if ($urandom_range(0, 1)) p.a_w = '0; else p.a_h = '0;
                if ($urandom_range(0, 2) == 0) begin
                    if ($urandom_range(0, 1)) p.b_w = '0; else p.b_h = '0;
                end
            end
            SHAPE_NESTED: begin
                p.b_w = 15'($urandom_range(0, p.a_w));
                p.b_h = 15'($urandom_range(0, p.a_h));
                p.b_x = 16'(int'(p.a_x) + int'($urandom_range(0, p.a_w - p.b_w)));
                p.b_y = 16'(int'(p.a_y) + int'($urandom_range(0, p.a_h - p.b_h)));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input t_box_pair p);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= biou_pkg::IN_DATA_W'(p);
        do @(posedge i_clk); while (!o_s_tready);
        iou_expected.insert(iou_expected.size(), iou_predict(p));
    endtask

    task automatic wait_drained();
        while (iou_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_identical_extremes();
        send_pair(make_pair(0, 0, 100, 50, 0, 0, 100, 50));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(0, 0, 32767, 32767, 0, 0, 32767, 32766));
        send_pair(make_pair(-32768, 32767, 32767, 1, 32767, -32768, 1, 32767));
    endtask

    task automatic test_zero_union();
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        send_pair(make_pair(5, 5, 0, 0, -7, 3, 0, 10));
        send_pair(make_pair(-32768, -32768, 32767, 0, 32767, 32767, 0, 32767));
        send_pair(make_pair(5, 5, 0, 0, 0, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 0, 0, 0, 10, 5));
    endtask

    task automatic test_touching_and_separated();
        send_pair(make_pair(0, 0, 10, 10, 10, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 10, 10, 10, 5, 5));
        send_pair(make_pair(0, 0, 10, 10, 11, 0, 10, 10));
        send_pair(make_pair(0, 0, 10, 10, 0, -21, 10, 20));
        send_pair(make_pair(0, 0, 10, 10, -5, -20, 4, 30));
        send_pair(make_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -1, -1, 32767, 32767));
        send_pair(make_pair(-32768, -32768, 32767, 32767, -2, -2, 32767, 32767));
    endtask

    task automatic test_partial_and_nested();
        send_pair(make_pair(0, 0, 100, 100, 10, 10, 10, 10));
        send_pair(make_pair(-50, -40, 100, 80, 0, 0, 100, 80));
        send_pair(make_pair(100, -200, 3, 7, 101, -199, 5, 2));
        send_pair(make_pair(-1000, 1000, 300, 30, -900, 990, 30, 300));
    endtask

    task automatic test_random_pairs(input int count);
        repeat (count) send_pair(random_pair());
    endtask

    task automatic test_drain_pause();
        repeat (20) send_pair(random_pair());
        i_s_tvalid <= 1'b0;
        wait_drained();
    endtask

    // Output check and receiver backpressure.
    always @(posedge i_clk) begin
        t_iou_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (iou_expected.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected word: ratio %0d union_zero %0d",
                             o_m_tdata[biou_pkg::QUO_W-1:0], o_m_tuser[0]);
            end else begin
                want = iou_expected.pop_front();
                if (o_m_tdata[biou_pkg::QUO_W-1:0] !== want.ratio ||
                    o_m_tuser[0] !== want.union_zero) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("mismatch: ratio exp %0d got %0d, union_zero exp %0d got %0d",
                                 want.ratio, o_m_tdata[biou_pkg::QUO_W-1:0],
                                 want.union_zero, o_m_tuser[0]);
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold    <= rx_hold - 1;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold    <= $urandom_range(0, 5);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identical_extremes();
        test_zero_union();
        test_touching_and_separated();
        test_partial_and_nested();
        idle_on = 1'b1;
        test_random_pairs(400);
        test_drain_pause();
        test_random_pairs(100);
        idle_on = 1'b0;
        test_random_pairs(210);
        i_s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
